/* rtl/core/scalar_kalman_filter_core_assert.svh */
// Assertion macros for the scalar Kalman filter core.
// SKF_ASSERT_IMP checks a same-cycle implication, SKF_ASSERT_NXT one
// that lands on the following clock edge.
`ifndef SCALAR_KALMAN_FILTER_CORE_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SKF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("skf: same-cycle check failed");
`define SKF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("skf: next-cycle check failed");
`else
`define SKF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SKF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/skf_pkg.sv */
package skf_pkg;

    // Data widths and fixed-point format
    localparam int DW        = 32;
    localparam int PW        = DW - 1;
    localparam int PRW       = 2 * DW;
    localparam int FRAC_BITS = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_CNT_W = $clog2(DW);

    localparam logic signed [PRW-1:0] SMAX = {{(PRW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [PRW-1:0] SMIN = ~SMAX;
    localparam logic signed [PRW-1:0] ONE  = PRW'(1) << FRAC_BITS;
    localparam logic signed [PRW-1:0] HALF = PRW'(1) << (FRAC_BITS - 1);

    // Divider quotient limits and last iteration
    localparam logic [DW-1:0] QPOS_LIM = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] QNEG_LIM = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(DW - 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION_GAIN    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_OBSERVE_GAIN       = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COVARIANCE = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ESTIMATE   = CFG_IDX_W'(5);

    // Reset values (Q16.16)
    localparam logic [PW-1:0] RST_PROCESS_NOISE      = PW'(6554);
    localparam logic [PW-1:0] RST_MEASURE_NOISE      = PW'(6554);
    localparam logic [DW-1:0] RST_TRANSITION_GAIN    = DW'(52429);
    localparam logic [DW-1:0] RST_OBSERVE_GAIN       = DW'(78643);
    localparam logic [PW-1:0] RST_INITIAL_COVARIANCE = PW'(6554);
    localparam logic [DW-1:0] RST_INITIAL_ESTIMATE   = '0;

    typedef struct packed {
        logic [PW-1:0] process_noise;
        logic [PW-1:0] measure_noise;
        logic [DW-1:0] transition_gain;
        logic [DW-1:0] observe_gain;
        logic [PW-1:0] initial_covariance;
        logic [DW-1:0] initial_estimate;
    } t_cfg;

    // Multiplier operand pairs
    typedef enum logic [3:0] {
        MUL_NONE, MUL_FX, MUL_FP, MUL_TF, MUL_HPP,
        MUL_TH, MUL_HXP, MUL_KI, MUL_KH, MUL_APP
    } t_mul_op;

    // Add/saturate operations and their destinations
    typedef enum logic [2:0] {
        ALU_NONE, ALU_XP, ALU_PP, ALU_S, ALU_INNOV, ALU_K, ALU_XN, ALU_A
    } t_alu_op;

    typedef struct packed {
        logic    load;
        t_mul_op mul_op;
        logic    rnd_en;
        logic    num_load;
        t_alu_op alu_op;
        logic    div_start;
        logic    commit;
    } t_dp_cmd;

    typedef struct packed {
        logic zden;
        logic div_done;
    } t_dp_sts;

    typedef enum logic [4:0] {
        ST_IDLE, ST_M_FX, ST_R_FX, ST_M_FP, ST_R_FP, ST_M_TF, ST_R_TF, ST_PP,
        ST_M_HPP, ST_R_HPP, ST_M_TH, ST_R_TH, ST_S, ST_R_HXP, ST_INNOV,
        ST_DIV_WAIT, ST_M_KI, ST_R_KI, ST_XN, ST_R_KH, ST_A, ST_M_APP,
        ST_R_APP, ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        DIV_IDLE, DIV_PREP, DIV_RUN, DIV_DONE
    } t_div_state;

    typedef struct packed {
        logic          clip;
        logic [DW-1:0] val;
    } t_sat;

    typedef struct packed {
        logic          clip;
        logic [PW-1:0] val;
    } t_satp;

    // Saturate to the signed data range
    function automatic t_sat sat_s(input logic signed [PRW-1:0] v);
        t_sat r;
        if (v > SMAX) begin
            r.clip = 1'b1;
            r.val  = SMAX[DW-1:0];
        end else if (v < SMIN) begin
            r.clip = 1'b1;
            r.val  = SMIN[DW-1:0];
        end else begin
            r.clip = 1'b0;
            r.val  = v[DW-1:0];
        end
        return r;
    endfunction

    // Clamp a covariance to 0 .. max positive
    function automatic t_satp clamp_p(input logic signed [PRW-1:0] v);
        t_satp r;
        if (v < 0) begin
            r.clip = 1'b1;
            r.val  = '0;
        end else if (v > SMAX) begin
            r.clip = 1'b1;
            r.val  = SMAX[PW-1:0];
        end else begin
            r.clip = 1'b0;
            r.val  = v[PW-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/core/skf_div.sv */
// Restoring divider: 64-bit signed dividend by 32-bit signed divisor,
// truncated towards zero and saturated to 32 bits. One bit per cycle.
module skf_div import skf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [PRW-1:0] i_num,
    input  logic signed [DW-1:0]  i_den,
    output logic                  o_done,
    output logic signed [DW-1:0]  o_quot,
    output logic                  o_clip
);

    t_div_state r_state, n_state;

    logic [PRW-1:0]       r_nmag;
    logic [DW-1:0]        r_dmag;
    logic [DW-1:0]        r_rem;
    logic [DW-1:0]        r_lo;
    logic                 r_neg;
    logic                 r_ovf;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [PRW-1:0] num_mag;
    logic [DW-1:0]  den_mag;
    logic           ovf_now;
    logic [DW:0]    shifted;
    logic [DW:0]    diff;
    logic           fits;

    // Operand magnitudes
    assign num_mag = i_num[PRW-1] ? PRW'(-i_num) : PRW'(i_num);
    assign den_mag = i_den[DW-1]  ? DW'(-i_den)  : DW'(i_den);

    // Quotient of 2^32 or more whenever the upper half reaches the divisor
    assign ovf_now = (r_nmag[PRW-1:DW] >= r_dmag);

    // One restoring step
    assign shifted = {r_rem, r_lo[DW-1]};
    assign diff    = shifted - {1'b0, r_dmag};
    assign fits    = (shifted >= {1'b0, r_dmag});

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DIV_IDLE: if (i_start) n_state = DIV_PREP;
            DIV_PREP: n_state = ovf_now ? DIV_DONE : DIV_RUN;
            DIV_RUN:  if (r_cnt == DIV_CNT_LAST) n_state = DIV_DONE;
            DIV_DONE: if (i_start) n_state = DIV_PREP;
        endcase
    end

    // Outputs: sign and saturate the quotient
    always_comb begin
        o_done = (r_state == DIV_DONE);
        o_clip = r_ovf | (r_neg ? (r_lo > QNEG_LIM) : (r_lo > QPOS_LIM));
        if (o_clip) begin
            o_quot = r_neg ? QNEG_LIM : QPOS_LIM;
        end else begin
            o_quot = r_neg ? -r_lo : r_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Operand and iteration registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nmag <= num_mag;
            r_dmag <= den_mag;
            r_neg  <= i_num[PRW-1] ^ i_den[DW-1];
        end else if (r_state == DIV_PREP) begin
            r_ovf <= ovf_now;
            r_rem <= r_nmag[PRW-1:DW];
            r_lo  <= r_nmag[DW-1:0];
            r_cnt <= '0;
        end else if (r_state == DIV_RUN) begin
            r_rem <= fits ? diff[DW-1:0] : shifted[DW-1:0];
            r_lo  <= {r_lo[DW-2:0], fits};
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
    end

endmodule

/* rtl/core/skf_dp.sv */
// Filter datapath: one shared multiplier, rounding stage, add/saturate
// unit and divider, plus the estimate/covariance state and result registers.
module skf_dp import skf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic signed [DW-1:0] i_measurement,
    input  logic                 i_restart,
    input  logic                 i_last_in,
    output logic signed [DW-1:0] o_estimate,
    output logic signed [DW-1:0] o_gain,
    output logic [PW-1:0]        o_covariance,
    output logic                 o_saturated,
    output logic                 o_zero_denominator,
    output logic                 o_last_out
);

    // Filter state
    logic signed [DW-1:0]  r_x;
    logic [PW-1:0]         r_p;

    // Working registers
    logic signed [DW-1:0]  r_z;
    logic                  r_last;
    logic signed [PRW-1:0] r_prod;
    logic signed [DW-1:0]  r_t;
    logic signed [DW-1:0]  r_xp;
    logic [PW-1:0]         r_pp;
    logic signed [DW-1:0]  r_s;
    logic signed [PRW-1:0] r_num;
    logic signed [DW-1:0]  r_innov;
    logic signed [DW-1:0]  r_k;
    logic signed [DW-1:0]  r_xn;
    logic signed [DW-1:0]  r_a;
    logic                  r_clip;
    logic                  r_zden;

    // Result registers
    logic signed [DW-1:0]  r_est;
    logic signed [DW-1:0]  r_gain;
    logic [PW-1:0]         r_cov;
    logic                  r_sat;
    logic                  r_zden_out;
    logic                  r_last_out;

    logic signed [DW-1:0]  f_s, h_s, p_s, pp_s;
    logic signed [DW-1:0]  mul_a, mul_b;
    logic signed [PRW-1:0] mul_res;
    logic signed [PRW-1:0] rnd_sum, rnd_sh;
    t_sat                  rnd;
    logic signed [PRW-1:0] t64;
    t_sat                  alu_res;
    t_satp                 alu_pp;
    logic                  alu_clip;
    t_satp                 pn;
    logic                  div_done;
    logic signed [DW-1:0]  div_q;
    logic                  div_clip;

    assign f_s  = i_cfg.transition_gain;
    assign h_s  = i_cfg.observe_gain;
    assign p_s  = {1'b0, r_p};
    assign pp_s = {1'b0, r_pp};
    assign t64  = PRW'(r_t);

    // Multiplier operand select
    always_comb begin
        unique case (i_cmd.mul_op)
            MUL_FX:  begin mul_a = f_s;  mul_b = r_x;     end
            MUL_FP:  begin mul_a = f_s;  mul_b = p_s;     end
            MUL_TF:  begin mul_a = r_t;  mul_b = f_s;     end
            MUL_HPP: begin mul_a = pp_s; mul_b = h_s;     end
            MUL_TH:  begin mul_a = r_t;  mul_b = h_s;     end
            MUL_HXP: begin mul_a = h_s;  mul_b = r_xp;    end
            MUL_KI:  begin mul_a = r_k;  mul_b = r_innov; end
            MUL_KH:  begin mul_a = r_k;  mul_b = h_s;     end
            MUL_APP: begin mul_a = r_a;  mul_b = pp_s;    end
            default: begin mul_a = '0;   mul_b = '0;      end
        endcase
    end

    assign mul_res = PRW'(mul_a) * PRW'(mul_b);

    // Round to nearest (ties up), drop fraction bits, saturate
    assign rnd_sum = r_prod + HALF;
    assign rnd_sh  = rnd_sum >>> FRAC_BITS;
    assign rnd     = sat_s(rnd_sh);

    // Add and saturate
    always_comb begin
        alu_res = '0;
        alu_pp  = '0;
        unique case (i_cmd.alu_op)
            ALU_PP:    alu_pp  = clamp_p(t64 + PRW'(i_cfg.process_noise));
            ALU_S:     alu_res = sat_s(t64 + PRW'(i_cfg.measure_noise));
            ALU_INNOV: alu_res = sat_s(PRW'(r_z) - t64);
            ALU_K: begin
                if (!r_zden) begin
                    alu_res.val  = div_q;
                    alu_res.clip = div_clip;
                end
            end
            ALU_XN:    alu_res = sat_s(PRW'(r_xp) + t64);
            ALU_A:     alu_res = sat_s(ONE - t64);
            ALU_NONE, ALU_XP: begin
            end
        endcase
    end

    assign alu_clip = alu_res.clip | alu_pp.clip;

    // Updated covariance is the last rounded product, kept non-negative
    assign pn = clamp_p(t64);

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (r_s),
        .o_done  (div_done),
        .o_quot  (div_q),
        .o_clip  (div_clip)
    );

    assign o_sts.zden     = r_zden;
    assign o_sts.div_done = div_done;

    // Estimate and covariance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= RST_INITIAL_ESTIMATE;
            r_p <= RST_INITIAL_COVARIANCE;
        end else if (i_cmd.load && i_restart) begin
            r_x <= i_cfg.initial_estimate;
            r_p <= i_cfg.initial_covariance;
        end else if (i_cmd.commit) begin
            r_x <= r_xn;
            r_p <= pn.val;
        end
    end

    // Status flags of the request in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= 1'b0;
            r_zden <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_clip <= 1'b0;
            end else begin
                r_clip <= r_clip | (i_cmd.rnd_en & rnd.clip) | alu_clip;
            end
            if (i_cmd.alu_op == ALU_S) begin
                r_zden <= (alu_res.val == '0);
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_z    <= i_measurement;
            r_last <= i_last_in;
        end
        if (i_cmd.mul_op != MUL_NONE) begin
            r_prod <= mul_res;
        end
        if (i_cmd.rnd_en) begin
            r_t <= rnd.val;
        end
        if (i_cmd.num_load) begin
            r_num <= r_prod;
        end
        unique case (i_cmd.alu_op)
            ALU_XP:    r_xp    <= r_t;
            ALU_PP:    r_pp    <= alu_pp.val;
            ALU_S:     r_s     <= alu_res.val;
            ALU_INNOV: r_innov <= alu_res.val;
            ALU_K:     r_k     <= alu_res.val;
            ALU_XN:    r_xn    <= alu_res.val;
            ALU_A:     r_a     <= alu_res.val;
            ALU_NONE: begin
            end
        endcase
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_est      <= r_xn;
            r_gain     <= r_k;
            r_cov      <= pn.val;
            r_sat      <= r_clip | pn.clip;
            r_zden_out <= r_zden;
            r_last_out <= r_last;
        end
    end

    assign o_estimate         = r_est;
    assign o_gain             = r_gain;
    assign o_covariance       = r_cov;
    assign o_saturated        = r_sat;
    assign o_zero_denominator = r_zden_out;
    assign o_last_out         = r_last_out;

endmodule

/* rtl/core/skf_ctrl.sv */
// Step sequencer: walks one request through predict, gain and update,
// and owns the result valid flag.
module skf_ctrl import skf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // Result register may be overwritten
    assign out_free = !(r_out_valid && i_out_stall);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_M_FX;
            ST_M_FX:     n_state = ST_R_FX;
            ST_R_FX:     n_state = ST_M_FP;
            ST_M_FP:     n_state = ST_R_FP;
            ST_R_FP:     n_state = ST_M_TF;
            ST_M_TF:     n_state = ST_R_TF;
            ST_R_TF:     n_state = ST_PP;
            ST_PP:       n_state = ST_M_HPP;
            ST_M_HPP:    n_state = ST_R_HPP;
            ST_R_HPP:    n_state = ST_M_TH;
            ST_M_TH:     n_state = ST_R_TH;
            ST_R_TH:     n_state = ST_S;
            ST_S:        n_state = ST_R_HXP;
            ST_R_HXP:    n_state = ST_INNOV;
            ST_INNOV:    n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: if (i_sts.zden || i_sts.div_done) n_state = ST_M_KI;
            ST_M_KI:     n_state = ST_R_KI;
            ST_R_KI:     n_state = ST_XN;
            ST_XN:       n_state = ST_R_KH;
            ST_R_KH:     n_state = ST_A;
            ST_A:        n_state = ST_M_APP;
            ST_M_APP:    n_state = ST_R_APP;
            ST_R_APP:    n_state = ST_DONE;
            ST_DONE:     if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE:     o_cmd.load = i_in_valid;
            ST_M_FX:     o_cmd.mul_op = MUL_FX;
            ST_M_FP: begin
                o_cmd.mul_op = MUL_FP;
                o_cmd.alu_op = ALU_XP;
            end
            ST_M_TF:     o_cmd.mul_op = MUL_TF;
            ST_PP:       o_cmd.alu_op = ALU_PP;
            ST_M_HPP:    o_cmd.mul_op = MUL_HPP;
            ST_R_HPP: begin
                o_cmd.rnd_en   = 1'b1;
                o_cmd.num_load = 1'b1;
            end
            ST_M_TH:     o_cmd.mul_op = MUL_TH;
            ST_S: begin
                o_cmd.alu_op = ALU_S;
                o_cmd.mul_op = MUL_HXP;
            end
            ST_R_HXP: begin
                o_cmd.rnd_en    = 1'b1;
                o_cmd.div_start = !i_sts.zden;
            end
            ST_INNOV:    o_cmd.alu_op = ALU_INNOV;
            ST_DIV_WAIT: begin
                if (i_sts.zden || i_sts.div_done) o_cmd.alu_op = ALU_K;
            end
            ST_M_KI:     o_cmd.mul_op = MUL_KI;
            ST_XN: begin
                o_cmd.mul_op = MUL_KH;
                o_cmd.alu_op = ALU_XN;
            end
            ST_A:        o_cmd.alu_op = ALU_A;
            ST_M_APP:    o_cmd.mul_op = MUL_APP;
            ST_R_FX, ST_R_FP, ST_R_TF, ST_R_TH, ST_R_KI, ST_R_KH, ST_R_APP:
                         o_cmd.rnd_en = 1'b1;
            ST_DONE:     o_cmd.commit = out_free;
            default: begin
            end
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/core/scalar_kalman_filter_core.sv */
// Scalar Kalman filter, signed Q16.16 with saturation.
// One request at a time: the input stalls from acceptance until the result is committed.
// The 32-step divider is skipped when the denominator is zero and cut short when
// the gain quotient overflows 32 bits.
// Reset (synchronous, active low): configuration registers take their defaults,
// estimate 0, covariance 6554, sequencer idle and no result pending.
`include "scalar_kalman_filter_core_assert.svh"

module scalar_kalman_filter_core import skf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [DW-1:0] i_measurement,
    input  logic                 i_restart,
    input  logic                 i_last_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [DW-1:0] o_estimate,
    output logic signed [DW-1:0] o_gain,
    output logic [PW-1:0]        o_covariance,
    output logic                 o_saturated,
    output logic                 o_zero_denominator,
    output logic                 o_last_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DW-1:0]        i_cfg_data
);

    t_cfg    r_cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    // Register file always takes writes
    assign o_cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{process_noise:      RST_PROCESS_NOISE,
                       measure_noise:      RST_MEASURE_NOISE,
                       transition_gain:    RST_TRANSITION_GAIN,
                       observe_gain:       RST_OBSERVE_GAIN,
                       initial_covariance: RST_INITIAL_COVARIANCE,
                       initial_estimate:   RST_INITIAL_ESTIMATE};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROCESS_NOISE:      r_cfg.process_noise      <= i_cfg_data[PW-1:0];
                CFG_MEASURE_NOISE:      r_cfg.measure_noise      <= i_cfg_data[PW-1:0];
                CFG_TRANSITION_GAIN:    r_cfg.transition_gain    <= i_cfg_data;
                CFG_OBSERVE_GAIN:       r_cfg.observe_gain       <= i_cfg_data;
                CFG_INITIAL_COVARIANCE: r_cfg.initial_covariance <= i_cfg_data[PW-1:0];
                CFG_INITIAL_ESTIMATE:   r_cfg.initial_estimate   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    skf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    skf_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_measurement      (i_measurement),
        .i_restart          (i_restart),
        .i_last_in          (i_last_in),
        .o_estimate         (o_estimate),
        .o_gain             (o_gain),
        .o_covariance       (o_covariance),
        .o_saturated        (o_saturated),
        .o_zero_denominator (o_zero_denominator),
        .o_last_out         (o_last_out)
    );

    // A pending result is never overwritten
    `SKF_ASSERT_IMP(a_commit_free, i_clk, i_rst_n, cmd.commit, !(o_out_valid && i_out_stall))
    // An accepted request closes the input until it is done
    `SKF_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // The divider is never started on a zero denominator
    `SKF_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, cmd.div_start, !sts.zden)
    // Every commit shows up as a valid result
    `SKF_ASSERT_NXT(a_commit_valid, i_clk, i_rst_n, cmd.commit, o_out_valid)

endmodule
